@@ rtl/ps2s1_pkg.sv @@
// shared constants, types and key tables for the set 1 scancode translator
// no dependencies

package ps2s1_pkg;

  localparam int unsigned ScWidth   = 8;
  localparam int unsigned CharWidth = 7;
  localparam int unsigned IdxWidth  = 6;

  localparam logic [ScWidth-1:0] ScPrefixExt = 8'hE0;
  localparam logic [ScWidth-1:0] ScBreakBit  = 8'h80;
  localparam logic [ScWidth-1:0] ScLeft      = 8'h4B;
  localparam logic [ScWidth-1:0] ScRight     = 8'h4D;
  localparam logic [ScWidth-1:0] ScLShift    = 8'h2A;
  localparam logic [ScWidth-1:0] ScRShift    = 8'h36;
  localparam logic [ScWidth-1:0] ScLCtrl     = 8'h1D;
  localparam logic [ScWidth-1:0] ScKeyC      = 8'h2E;
  localparam logic [ScWidth-1:0] ScKeyV      = 8'h2F;
  localparam logic [ScWidth-1:0] ScTableLen  = 8'd59;

  localparam logic [CharWidth-1:0] CodeCopy  = 7'h03;
  localparam logic [CharWidth-1:0] CodePaste = 7'h16;
  localparam logic [CharWidth-1:0] CodeLeft  = 7'h11;
  localparam logic [CharWidth-1:0] CodeRight = 7'h12;

  // one decoded byte: does it give a character, and which
  typedef struct packed {
    logic                 emit;
    logic [CharWidth-1:0] code;
  } ps2s1_result_t;

  // us layout, plain and shifted; zero means no character
  function automatic logic [CharWidth-1:0] key_lookup(input logic shift,
                                                      input logic [IdxWidth-1:0] idx);
    logic [CharWidth-1:0] plain_c;
    logic [CharWidth-1:0] shift_c;
    plain_c = '0;
    shift_c = '0;
    case (idx)
      6'd2:  begin plain_c = 7'h31; shift_c = 7'h21; end
      6'd3:  begin plain_c = 7'h32; shift_c = 7'h40; end
      6'd4:  begin plain_c = 7'h33; shift_c = 7'h23; end
      6'd5:  begin plain_c = 7'h34; shift_c = 7'h24; end
      6'd6:  begin plain_c = 7'h35; shift_c = 7'h25; end
      6'd7:  begin plain_c = 7'h36; shift_c = 7'h5E; end
      6'd8:  begin plain_c = 7'h37; shift_c = 7'h26; end
      6'd9:  begin plain_c = 7'h38; shift_c = 7'h2A; end
      6'd10: begin plain_c = 7'h39; shift_c = 7'h28; end
      6'd11: begin plain_c = 7'h30; shift_c = 7'h29; end
      6'd12: begin plain_c = 7'h2D; shift_c = 7'h5F; end
      6'd13: begin plain_c = 7'h3D; shift_c = 7'h2B; end
      6'd14: begin plain_c = 7'h08; shift_c = 7'h08; end
      6'd15: begin plain_c = 7'h09; shift_c = 7'h09; end
      6'd16: begin plain_c = 7'h71; shift_c = 7'h51; end
      6'd17: begin plain_c = 7'h77; shift_c = 7'h57; end
      6'd18: begin plain_c = 7'h65; shift_c = 7'h45; end
      6'd19: begin plain_c = 7'h72; shift_c = 7'h52; end
      6'd20: begin plain_c = 7'h74; shift_c = 7'h54; end
      6'd21: begin plain_c = 7'h79; shift_c = 7'h59; end
      6'd22: begin plain_c = 7'h75; shift_c = 7'h55; end
      6'd23: begin plain_c = 7'h69; shift_c = 7'h49; end
      6'd24: begin plain_c = 7'h6F; shift_c = 7'h4F; end
      6'd25: begin plain_c = 7'h70; shift_c = 7'h50; end
      6'd26: begin plain_c = 7'h5B; shift_c = 7'h7B; end
      6'd27: begin plain_c = 7'h5D; shift_c = 7'h7D; end
      6'd28: begin plain_c = 7'h0A; shift_c = 7'h0A; end
      6'd30: begin plain_c = 7'h61; shift_c = 7'h41; end
      6'd31: begin plain_c = 7'h73; shift_c = 7'h53; end
      6'd32: begin plain_c = 7'h64; shift_c = 7'h44; end
      6'd33: begin plain_c = 7'h66; shift_c = 7'h46; end
      6'd34: begin plain_c = 7'h67; shift_c = 7'h47; end
      6'd35: begin plain_c = 7'h68; shift_c = 7'h48; end
      6'd36: begin plain_c = 7'h6A; shift_c = 7'h4A; end
      6'd37: begin plain_c = 7'h6B; shift_c = 7'h4B; end
      6'd38: begin plain_c = 7'h6C; shift_c = 7'h4C; end
      6'd39: begin plain_c = 7'h3B; shift_c = 7'h3A; end
      6'd40: begin plain_c = 7'h27; shift_c = 7'h22; end
      6'd41: begin plain_c = 7'h60; shift_c = 7'h7E; end
      6'd43: begin plain_c = 7'h5C; shift_c = 7'h7C; end
      6'd44: begin plain_c = 7'h7A; shift_c = 7'h5A; end
      6'd45: begin plain_c = 7'h78; shift_c = 7'h58; end
      6'd46: begin plain_c = 7'h63; shift_c = 7'h43; end
      6'd47: begin plain_c = 7'h76; shift_c = 7'h56; end
      6'd48: begin plain_c = 7'h62; shift_c = 7'h42; end
      6'd49: begin plain_c = 7'h6E; shift_c = 7'h4E; end
      6'd50: begin plain_c = 7'h6D; shift_c = 7'h4D; end
      6'd51: begin plain_c = 7'h2C; shift_c = 7'h3C; end
      6'd52: begin plain_c = 7'h2E; shift_c = 7'h3E; end
      6'd53: begin plain_c = 7'h2F; shift_c = 7'h3F; end
      6'd55: begin plain_c = 7'h2A; shift_c = 7'h2A; end
      6'd57: begin plain_c = 7'h20; shift_c = 7'h20; end
      default: begin plain_c = '0; shift_c = '0; end
    endcase
    return shift ? shift_c : plain_c;
  endfunction

endpackage

@@ rtl/ps2s1_decode.sv @@
// modifier and prefix flags plus byte decode into an optional character
// depends on ps2s1_pkg

module ps2s1_decode (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [ps2s1_pkg::ScWidth-1:0]        sc_i,
  input  logic                                 advance_i,
  output ps2s1_pkg::ps2s1_result_t             result_o
);
  import ps2s1_pkg::*;

  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic ext_q, ext_d;

  always_comb begin
    shift_d         = shift_q;
    ctrl_d          = ctrl_q;
    ext_d           = ext_q;
    result_o.emit   = 1'b0;
    result_o.code   = '0;
    if (sc_i == ScPrefixExt) begin
      ext_d = 1'b1;
    end else if (ext_q) begin
      // extended byte: only the arrows give something
      ext_d = 1'b0;
      if (sc_i == ScLeft) begin
        result_o.emit = 1'b1;
        result_o.code = CodeLeft;
      end else if (sc_i == ScRight) begin
        result_o.emit = 1'b1;
        result_o.code = CodeRight;
      end
    end else if (sc_i == ScLShift || sc_i == ScRShift) begin
      shift_d = 1'b1;
    end else if (sc_i == (ScLShift | ScBreakBit) || sc_i == (ScRShift | ScBreakBit)) begin
      shift_d = 1'b0;
    end else if (sc_i == ScLCtrl) begin
      ctrl_d = 1'b1;
    end else if (sc_i == (ScLCtrl | ScBreakBit)) begin
      ctrl_d = 1'b0;
    end else if ((sc_i & ScBreakBit) != '0) begin
      // other break codes give nothing
    end else if (ctrl_q && sc_i == ScKeyC) begin
      result_o.emit = 1'b1;
      result_o.code = CodeCopy;
    end else if (ctrl_q && sc_i == ScKeyV) begin
      result_o.emit = 1'b1;
      result_o.code = CodePaste;
    end else if (sc_i < ScTableLen) begin
      result_o.code = key_lookup(shift_q, sc_i[IdxWidth-1:0]);
      result_o.emit = (result_o.code != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      ext_q   <= 1'b0;
    end else if (advance_i) begin
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      ext_q   <= ext_d;
    end
  end

endmodule

@@ rtl/ps2s1_out_reg.sv @@
// result register toward the output channel
// depends on ps2s1_pkg

module ps2s1_out_reg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic [ps2s1_pkg::CharWidth-1:0]      code_i,
  output logic                                 free_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ps2s1_pkg::CharWidth-1:0]      char_code_o
);
  import ps2s1_pkg::*;

  logic                 valid_q;
  logic [CharWidth-1:0] code_q;

  // free when empty or when the held result leaves this cycle
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign char_code_o = code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      code_q <= code_i;
    end
  end

endmodule

@@ rtl/ps2s1_input_reg.sv @@
// input register for raw scancode bytes
// depends on ps2s1_pkg

module ps2s1_input_reg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ps2s1_pkg::ScWidth-1:0]        scancode_i,
  input  logic                                 advance_i,
  output logic                                 valid_o,
  output logic [ps2s1_pkg::ScWidth-1:0]        sc_o
);
  import ps2s1_pkg::*;

  logic               valid_q;
  logic [ScWidth-1:0] sc_q;
  logic               take;

  // a held byte that cannot move on blocks the input
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign sc_o       = sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sc_q <= scancode_i;
    end
  end

endmodule

@@ rtl/ps2s1_set1_scancode_to_ascii_unit.sv @@
// top level of the set 1 scancode to ascii translator, us layout
// depends on ps2s1_pkg, ps2s1_input_reg, ps2s1_decode, ps2s1_out_reg

// Translates raw PS/2 set 1 keyboard bytes into 7-bit character codes, one
// byte per transfer on the input side and zero or one character per byte on
// the output side. Shift (left or right) and left ctrl are tracked as held
// flags, and an 0xE0 prefix marks the next byte as extended: after it only
// the left and right arrow make codes give 0x11 and 0x12, everything else is
// dropped. With ctrl held, the c and v keys give 0x03 and 0x16. Other make
// codes up to 0x3A go through the us plain or shifted key table, and keys
// without a character, break codes and codes above the table give nothing.
// A byte is registered on input, decoded against the flags in the next cycle
// and its character (if any) is written to the result register, which drives
// output valid; one byte can be taken every cycle while no byte waits for the
// result register. A byte that gives no character never waits for the output
// side; one that does waits only while the result register is full and
// stalled. There is no configuration and no clearing pass after reset.

module ps2_set1_scancode_to_ascii_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ps2s1_pkg::ScWidth-1:0]        scancode_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ps2s1_pkg::CharWidth-1:0]      char_code_o
);
  import ps2s1_pkg::*;

  logic               s1_valid;
  logic [ScWidth-1:0] s1_sc;
  logic               s1_advance;
  ps2s1_result_t      dec_result;
  logic               out_free;
  logic               push;

  // held byte at the input stage
  ps2s1_input_reg u_input_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scancode_i (scancode_i),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .sc_o       (s1_sc)
  );

  // flags only move when the held byte is consumed, keeping byte order
  ps2s1_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sc_i      (s1_sc),
    .advance_i (s1_advance),
    .result_o  (dec_result)
  );

  // a byte without a character leaves at once, otherwise it needs room
  assign s1_advance = s1_valid && (!dec_result.emit || out_free);
  assign push       = s1_advance && dec_result.emit;

  ps2s1_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .code_i      (dec_result.code),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o)
  );

endmodule

@@ verif/tb_ps2_set1_scancode_to_ascii_unit.sv @@
// self-checking testbench for ps2_set1_scancode_to_ascii_unit: directed and random set 1
// byte streams, predicted char codes compared in order; depends on ps2s1_pkg and the rtl

module tb_ps2_set1_scancode_to_ascii_unit;
  import ps2s1_pkg::*;

  // run shape
  localparam int unsigned TargetBytes = 1550;  // bytes to send
  localparam int unsigned CycleLimit = 200000; // far above the slowest legal run
  localparam int unsigned DrainWait  = 10;     // quiet spell to catch stray chars
  localparam int unsigned MaxPrinted = 40;

  // receiver stall patterns
  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallHeavy,
    StallEveryThird
  } stall_mode_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [ScWidth-1:0]   scancode_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CharWidth-1:0] char_code_o;

  ps2_set1_scancode_to_ascii_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scancode_i  (scancode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o)
  );

  // period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // us layout, indexed by make code 0x00..0x3a; zero means no character
  logic [CharWidth-1:0] plain_tbl [0:58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };
  logic [CharWidth-1:0] shift_tbl [0:58] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  // keyboard state as the translator should see it
  logic shift_st = 1'b0;
  logic ctrl_st  = 1'b0;
  logic ext_st   = 1'b0;

  logic [ScWidth-1:0]   pending_scancodes [$]; // bytes still to be sent
  logic [CharWidth-1:0] expected_chars [$];    // chars owed by the dut, oldest first

  int unsigned err_cnt     = 0;
  int unsigned n_bytes     = 0;
  int unsigned total_bytes = 0;
  int unsigned n_keys      = 0;
  int unsigned n_chars     = 0;
  int unsigned n_special   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_run   = 0;
  int unsigned max_stall   = 0;
  int unsigned holds_done  = 0;
  logic        in_taken    = 1'b0;

  // one set 1 byte against the flags; returns 1 with the char when one is due
  function automatic bit decode_byte(input logic [ScWidth-1:0] sc,
                                     output logic [CharWidth-1:0] ch);
    ch = '0;
    // a prefix always arms, even when already armed
    if (sc == ScPrefixExt) begin
      ext_st = 1'b1;
      return 1'b0;
    end
    // extended byte: only the arrow makes count, modifiers untouched
    if (ext_st) begin
      ext_st = 1'b0;
      if (sc == ScLeft) begin
        ch = CodeLeft;
        return 1'b1;
      end
      if (sc == ScRight) begin
        ch = CodeRight;
        return 1'b1;
      end
      return 1'b0;
    end
    if (sc == ScLShift || sc == ScRShift) begin
      shift_st = 1'b1;
      return 1'b0;
    end
    if (sc == (ScLShift | ScBreakBit) || sc == (ScRShift | ScBreakBit)) begin
      shift_st = 1'b0;
      return 1'b0;
    end
    if (sc == ScLCtrl) begin
      ctrl_st = 1'b1;
      return 1'b0;
    end
    if (sc == (ScLCtrl | ScBreakBit)) begin
      ctrl_st = 1'b0;
      return 1'b0;
    end
    if ((sc & ScBreakBit) != '0) return 1'b0;
    if (ctrl_st && sc == ScKeyC) begin
      ch = CodeCopy;
      return 1'b1;
    end
    if (ctrl_st && sc == ScKeyV) begin
      ch = CodePaste;
      return 1'b1;
    end
    if (sc >= ScTableLen) return 1'b0;
    ch = shift_st ? shift_tbl[sc[IdxWidth-1:0]] : plain_tbl[sc[IdxWidth-1:0]];
    return ch != '0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // counts marks bytes that are tallied as keys or prefixes in n_keys
  task automatic add_byte(input logic [ScWidth-1:0] b, input bit counts = 1'b1);
    pending_scancodes.push_back(b);
    if (counts) n_keys++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps; a held payload stays put
  // until the transfer is seen at the rising edge
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_scancodes.size() != 0) begin
        in_valid_i <= 1'b1;
        scancode_i <= pending_scancodes.pop_front();
        if (burst_left <= 1) begin
          // mix of long back-to-back stretches and short choppy ones
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: segments of different stall patterns, plus two long hold-offs
  // while the sender keeps going so the pipe fills and stalls its input
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = StallNone;
  int unsigned seg_left   = 0;
  int unsigned seg_phase  = 0;
  int unsigned hold_left  = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if ((holds_done == 0 && n_bytes >= 300) ||
                 (holds_done == 1 && n_bytes >= 1000)) begin
      holds_done++;
      hold_left = $urandom_range(60, 120);
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        seg_left   = $urandom_range(16, 160);
        seg_phase  = 0;
      end
      seg_left--;
      seg_phase++;
      case (stall_mode)
        StallNone:       out_stall_i <= 1'b0;
        StallRandom:     out_stall_i <= ($urandom_range(0, 1) == 1);
        StallHeavy:      out_stall_i <= ($urandom_range(0, 3) != 0);
        StallEveryThird: out_stall_i <= (seg_phase % 3 == 0);
        default:         out_stall_i <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check output transfers against the oldest expectation, then
  // predict from input transfers; both sampled before the edge updates
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    logic [CharWidth-1:0] ch;
    logic [CharWidth-1:0] want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h with nothing expected", char_code_o));
        end else begin
          want = expected_chars.pop_front();
          if (char_code_o !== want)
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      char_code_o, want));
          if (want == CodeCopy || want == CodePaste || want == CodeLeft ||
              want == CodeRight)
            n_special++;
          n_chars++;
        end
      end
      if (in_valid_i && in_stall_o === 1'b0) begin
        if (decode_byte(scancode_i, ch)) expected_chars.push_back(ch);
        n_bytes++;
      end
      // length of the longest back-pressure run on the input
      if (in_valid_i && in_stall_o === 1'b1) begin
        stall_run++;
        if (stall_run > max_stall) max_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      in_taken <= in_valid_i && in_stall_o === 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars still owed", cycle_cnt,
               expected_chars.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned r;
    int unsigned k;
    logic [ScWidth-1:0] b;

    // directed: field extremes, table edges, modifiers, ctrl codes, prefixes
    pending_scancodes = {
      8'h00, 8'hFF, 8'h02, 8'h39, 8'h3A, 8'h3B, 8'h7F,  // edges, beyond table
      ScLShift, 8'h1E, 8'h02, ScLShift | ScBreakBit,    // shifted lookup
      ScRShift, ScRShift | ScBreakBit,
      ScLCtrl, ScKeyC, ScKeyV, 8'h1E,                   // copy, paste, ctrl + other
      ScLCtrl | ScBreakBit, ScKeyC,                     // plain c after release
      ScPrefixExt, ScPrefixExt, ScLeft,                 // repeated prefix
      ScPrefixExt, ScRight,
      ScPrefixExt, ScLCtrl, ScKeyC,                     // right ctrl is not ctrl
      ScPrefixExt, ScLShift, 8'h1E,                     // extended shift is dropped
      ScPrefixExt, ScLeft | ScBreakBit                  // extended break
    };
    n_keys = pending_scancodes.size();

    // random: mostly well-formed key sequences, some raw noise
    while (pending_scancodes.size() < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // ordinary key, often with its release
        b = ScWidth'($urandom_range(1, 58));
        add_byte(b);
        if ($urandom_range(0, 1) == 1) add_byte(b | ScBreakBit, 1'b0);
      end else if (r < 55) begin
        b = ($urandom_range(0, 1) == 1) ? ScLShift : ScRShift;
        add_byte(($urandom_range(0, 1) == 1) ? b : (b | ScBreakBit));
      end else if (r < 63) begin
        add_byte(($urandom_range(0, 1) == 1) ? ScLCtrl : (ScLCtrl | ScBreakBit));
      end else if (r < 73) begin
        // ctrl chord with a few keys inside
        add_byte(ScLCtrl);
        k = $urandom_range(1, 3);
        repeat (k) begin
          case ($urandom_range(0, 2))
            0:       add_byte(ScKeyC);
            1:       add_byte(ScKeyV);
            default: add_byte(ScWidth'($urandom_range(1, 58)));
          endcase
        end
        add_byte(ScLCtrl | ScBreakBit);
      end else if (r < 85) begin
        add_byte(ScPrefixExt);
        case ($urandom_range(0, 4))
          0:       add_byte(ScLeft);
          1:       add_byte(ScRight);
          2:       add_byte(ScLeft | ScBreakBit, 1'b0);
          3:       add_byte(ScRight | ScBreakBit, 1'b0);
          default: add_byte(ScWidth'($urandom_range(0, 255)), 1'b0);
        endcase
      end else if (r < 90) begin
        add_byte(ScPrefixExt);
        add_byte(ScPrefixExt);
        add_byte(($urandom_range(0, 1) == 1) ? ScLeft : ScRight);
      end else begin
        add_byte(ScWidth'($urandom_range(0, 255)));
      end
    end
    total_bytes = pending_scancodes.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // every byte accepted, every char delivered, then a short quiet spell
    while (n_bytes != total_bytes) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    while (expected_chars.size() != 0) begin
      report_mismatch($sformatf("char 0x%02h never arrived", expected_chars.pop_front()));
    end

    $display("covered %0d bytes in (%0d keys or prefixes), %0d chars out (%0d ctrl or arrow)",
             n_bytes, n_keys, n_chars, n_special);
    $display("longest input back-pressure %0d cycles, %0d receiver hold-offs, %0d errors",
             max_stall, holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
